### sv/tdma_slot_ack_retransmit_controller_assert.svh
// ---------------------------------------------------------------------------
// tdma slot controller assertion macros
// clocked assertion wrappers shared by the controller rtl
// ---------------------------------------------------------------------------
`ifndef TDMA_SLOT_ACK_RETRANSMIT_CONTROLLER_ASSERT_SVH
`define TDMA_SLOT_ACK_RETRANSMIT_CONTROLLER_ASSERT_SVH

// property that must hold at every edge outside reset
`define TSARC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("tsarc assertion failed");

// consequence that must hold in the cycle after the trigger
`define TSARC_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error("tsarc assertion failed");

`endif

### sv/tsarc_pkg.sv
// ---------------------------------------------------------------------------
// tsarc_pkg
// types and constants of the tdma slot, ack and retransmit controller
// ---------------------------------------------------------------------------
package tsarc_pkg;

    localparam int RESEND_DEPTH      = 32;
    localparam int PERIODS_PER_CYCLE = 5;
    localparam int PTR_W             = $clog2(RESEND_DEPTH);
    localparam int CNT_W             = $clog2(RESEND_DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RESEND_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(RESEND_DEPTH);

    localparam logic [2:0]  POS_FIRST  = 3'd1;
    localparam logic [2:0]  POS_LAST   = 3'(PERIODS_PER_CYCLE);
    localparam logic [2:0]  POS_RESEND = 3'd4;
    localparam logic [31:0] FIRST_CYCLE_PERIOD = 32'(PERIODS_PER_CYCLE + 1);

    localparam logic [1:0] MSG_NONE = 2'd0;
    localparam logic [1:0] MSG_SYNC = 2'd1;
    localparam logic [1:0] MSG_DATA = 2'd2;
    localparam logic [7:0] MSG_ACK  = 8'h03;

    localparam int         NUM_PEERS  = 9;
    localparam logic [8:0] ALL_PEERS  = 9'h1FF;
    localparam logic [7:0] NODE_ZERO  = 8'h30;
    localparam logic [7:0] NODE_BASE  = 8'h31;
    localparam logic [7:0] NODE_FIRST = 8'h32;
    localparam logic [7:0] NODE_LAST  = 8'h39;
    localparam logic [3:0] NODE_ZERO_IDX = 4'(NUM_PEERS);

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_SLOT_START = 2'd1,
        OP_SLOT_END   = 2'd2,
        OP_RX         = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_SYNC    = 3'd1,
        KIND_DATA    = 3'd2,
        KIND_RESEND  = 3'd3,
        KIND_SUMMARY = 3'd4,
        KIND_ACK     = 3'd5
    } t_kind;

endpackage

### sv/tdma_slot_ack_retransmit_controller.sv
// results are registered: a result appears in the cycle after its item is accepted
// throughput: one item per cycle; the result register reloads in the cycle its
// item leaves, so input stalls only while a valid result is itself stalled
// resend queue reads come from a registered prefetch of the head entry
// reset (synchronous, active low) clears counters, bitmap, queue pointers and
// the result valid flag; the resend store itself is not cleared
// ---------------------------------------------------------------------------
// tdma slot ack retransmit controller
// event driven tdma initiator: sync ticks, data and resend slots, ack
// bitmap and a retransmission queue
// ---------------------------------------------------------------------------
`include "tdma_slot_ack_retransmit_controller_assert.svh"

module tdma_slot_ack_retransmit_controller
    import tsarc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_rx_type,
    input  logic [7:0]  i_rx_sender,
    input  logic [7:0]  i_rx_sequence,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_result_kind,
    output logic [7:0]  o_frame_sequence,
    output logic [1:0]  o_frame_type,
    output logic        o_frame_priority,
    output logic        o_response_expected,
    output logic [2:0]  o_cycle_position,
    output logic [29:0] o_cycle_number,
    output logic        o_retry_number,
    output logic [3:0]  o_acks_seen,
    output logic        o_queued_for_resend,
    output logic        o_resend_dropped,
    output logic [3:0]  o_acked_node
);

    logic [31:0]      r_period;
    logic [2:0]       r_pos;
    logic [29:0]      r_cycle;
    logic [7:0]       r_data_seq;
    logic [7:0]       r_last_seq;
    logic             r_active;
    logic [8:0]       r_bitmap;
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;

    logic [31:0]      n_period;
    logic [2:0]       n_pos;
    logic [29:0]      n_cycle;
    logic [7:0]       n_data_seq;
    logic [7:0]       n_last_seq;
    logic             n_active;
    logic [8:0]       n_bitmap;
    logic [PTR_W-1:0] n_head;
    logic [PTR_W-1:0] n_tail;
    logic [CNT_W-1:0] n_count;

    logic [7:0]       r_mem [RESEND_DEPTH];
    logic [7:0]       r_mem_q;
    logic             r_fwd;
    logic [7:0]       r_fwd_data;
    logic [7:0]       w_head_data;
    logic             w_push;

    logic             r_out_valid;
    t_kind            r_kind;
    logic [7:0]       r_seq;
    logic [1:0]       r_ftype;
    logic             r_prio;
    logic             r_resp;
    logic             r_retry;
    logic [3:0]       r_acks;
    logic             r_queued;
    logic             r_dropped;
    logic [3:0]       r_acked;
    logic [2:0]       r_out_pos;
    logic [29:0]      r_out_cycle;

    t_kind            n_kind;
    logic [7:0]       n_seq;
    logic [1:0]       n_ftype;
    logic             n_prio;
    logic             n_resp;
    logic             n_retry;
    logic [3:0]       n_acks;
    logic             n_queued;
    logic             n_dropped;
    logic [3:0]       n_acked;

    logic             w_acc;
    logic [7:0]       w_sender_off;
    logic [3:0]       w_node;
    logic             w_node_ok;

    assign o_stall = r_out_valid && i_stall;
    assign w_acc   = i_valid && !o_stall;

    assign w_head_data  = r_fwd ? r_fwd_data : r_mem_q;
    assign w_sender_off = i_rx_sender - NODE_BASE;

    always_comb begin
        w_node    = '0;
        w_node_ok = 1'b0;
        if (i_rx_sender inside {[NODE_FIRST:NODE_LAST]}) begin
            w_node    = w_sender_off[3:0];
            w_node_ok = 1'b1;
        end else if (i_rx_sender == NODE_ZERO) begin
            w_node    = NODE_ZERO_IDX;
            w_node_ok = 1'b1;
        end
    end

    always_comb begin
        n_period   = r_period;
        n_pos      = r_pos;
        n_cycle    = r_cycle;
        n_data_seq = r_data_seq;
        n_last_seq = r_last_seq;
        n_active   = r_active;
        n_bitmap   = r_bitmap;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        w_push     = 1'b0;
        n_kind     = KIND_NONE;
        n_seq      = '0;
        n_ftype    = MSG_NONE;
        n_prio     = 1'b0;
        n_resp     = 1'b0;
        n_retry    = 1'b0;
        n_acks     = '0;
        n_queued   = 1'b0;
        n_dropped  = 1'b0;
        n_acked    = '0;
        if (w_acc) begin
            case (t_opcode'(i_opcode))
                OP_TICK: begin
                    n_period = r_period + 32'd1;
                    if (n_period == 32'd1 || r_pos == POS_LAST) begin
                        n_pos = POS_FIRST;
                    end else begin
                        n_pos = r_pos + 3'd1;
                    end
                    if (n_pos == POS_FIRST && n_period[31:1] != '0) begin
                        n_cycle = (n_period == FIRST_CYCLE_PERIOD) ? 30'd1 : r_cycle + 30'd1;
                    end
                    n_last_seq = n_period[7:0];
                    n_kind     = KIND_SYNC;
                    n_seq      = n_period[7:0];
                    n_ftype    = MSG_SYNC;
                end
                OP_SLOT_START: begin
                    if (!r_active) begin
                        if (r_pos == POS_FIRST) begin
                            n_bitmap   = '0;
                            n_data_seq = r_data_seq + 8'd1;
                            n_last_seq = n_data_seq;
                            n_active   = 1'b1;
                            n_kind     = KIND_DATA;
                            n_seq      = n_data_seq;
                            n_ftype    = MSG_DATA;
                            n_prio     = 1'b1;
                            n_resp     = 1'b1;
                        end else if ((r_pos == POS_RESEND || r_pos == POS_LAST)
                                     && r_count != '0) begin
                            n_last_seq = w_head_data;
                            n_head     = (r_head == PTR_LAST) ? '0 : r_head + PTR_W'(1);
                            n_count    = r_count - CNT_W'(1);
                            n_bitmap   = '0;
                            n_active   = 1'b1;
                            n_kind     = KIND_RESEND;
                            n_seq      = w_head_data;
                            n_ftype    = MSG_DATA;
                            n_prio     = 1'b1;
                            n_resp     = 1'b1;
                            n_retry    = 1'b1;
                        end
                    end
                end
                OP_SLOT_END: begin
                    if (r_active) begin
                        n_acks = 4'($countones(r_bitmap));
                        if (r_bitmap != ALL_PEERS) begin
                            if (r_count != CNT_FULL) begin
                                w_push   = 1'b1;
                                n_tail   = (r_tail == PTR_LAST) ? '0 : r_tail + PTR_W'(1);
                                n_count  = r_count + CNT_W'(1);
                                n_queued = 1'b1;
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        n_active = 1'b0;
                        n_kind   = KIND_SUMMARY;
                    end
                end
                OP_RX: begin
                    if (r_active && i_rx_type == MSG_ACK && i_rx_sequence == r_data_seq
                        && w_node_ok) begin
                        n_bitmap = r_bitmap | (9'd1 << (w_node - 4'd1));
                        n_kind   = KIND_ACK;
                        n_acked  = w_node;
                    end
                end
                default: begin
                    n_kind = KIND_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_tail] <= r_last_seq;
        end
        r_mem_q    <= r_mem[n_head];
        r_fwd_data <= r_last_seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= '0;
            r_pos      <= POS_FIRST;
            r_cycle    <= '0;
            r_data_seq <= '0;
            r_last_seq <= '0;
            r_active   <= 1'b0;
            r_bitmap   <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_fwd      <= 1'b0;
        end else begin
            r_period   <= n_period;
            r_pos      <= n_pos;
            r_cycle    <= n_cycle;
            r_data_seq <= n_data_seq;
            r_last_seq <= n_last_seq;
            r_active   <= n_active;
            r_bitmap   <= n_bitmap;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_fwd      <= w_push && (r_tail == n_head);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_stall) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_kind      <= n_kind;
            r_seq       <= n_seq;
            r_ftype     <= n_ftype;
            r_prio      <= n_prio;
            r_resp      <= n_resp;
            r_retry     <= n_retry;
            r_acks      <= n_acks;
            r_queued    <= n_queued;
            r_dropped   <= n_dropped;
            r_acked     <= n_acked;
            r_out_pos   <= n_pos;
            r_out_cycle <= n_cycle;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_result_kind       = r_kind;
    assign o_frame_sequence    = r_seq;
    assign o_frame_type        = r_ftype;
    assign o_frame_priority    = r_prio;
    assign o_response_expected = r_resp;
    assign o_cycle_position    = r_out_pos;
    assign o_cycle_number      = r_out_cycle;
    assign o_retry_number      = r_retry;
    assign o_acks_seen         = r_acks;
    assign o_queued_for_resend = r_queued;
    assign o_resend_dropped    = r_dropped;
    assign o_acked_node        = r_acked;

    `TSARC_ASSERT(a_count_bound, r_count <= CNT_FULL)
    `TSARC_ASSERT(a_empty_ptrs, (r_count != '0) || (r_head == r_tail))
    `TSARC_ASSERT(a_pos_range, (r_pos >= POS_FIRST) && (r_pos <= POS_LAST))
    `TSARC_ASSERT_NEXT(a_send_starts_xfer,
        w_acc && (n_kind == KIND_DATA || n_kind == KIND_RESEND), r_active)
    `TSARC_ASSERT_NEXT(a_data_seq_sent,
        w_acc && n_kind == KIND_DATA, (r_last_seq == r_data_seq) && (r_bitmap == '0))

endmodule

### bench/tb_tdma_slot_ack_retransmit_controller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tdma slot controller testbench
// drives period ticks, slot starts and ends and received frames through the
// valid/stall input channel, predicts each result item in a local model of
// the initiator and checks every returned item field by field, with random
// idle gaps and output stalls, a queue fill to overflow and resend drains
// ---------------------------------------------------------------------------
module tb_tdma_slot_ack_retransmit_controller;
    import tsarc_pkg::*;

    localparam logic [7:0] NODE_ALPHA = 8'h41;
    localparam logic [7:0] NODE_NONE  = 8'hFF;
    localparam int         PHASES     = 8;
    localparam int         PHASE_ITEMS = 90;

    typedef struct {
        t_opcode    op;
        logic [7:0] rtype;
        logic [7:0] sender;
        logic [7:0] rseq;
    } t_slot_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  seq;
        logic [1:0]  ftype;
        logic        prio;
        logic        resp;
        logic [2:0]  pos;
        logic [29:0] cyc;
        logic        retry;
        logic [3:0]  acks;
        logic        queued;
        logic        dropped;
        logic [3:0]  node;
    } t_frame_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = 2'd0;
    logic [7:0]  i_rx_type = 8'd0;
    logic [7:0]  i_rx_sender = 8'd0;
    logic [7:0]  i_rx_sequence = 8'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_result_kind;
    logic [7:0]  o_frame_sequence;
    logic [1:0]  o_frame_type;
    logic        o_frame_priority;
    logic        o_response_expected;
    logic [2:0]  o_cycle_position;
    logic [29:0] o_cycle_number;
    logic        o_retry_number;
    logic [3:0]  o_acks_seen;
    logic        o_queued_for_resend;
    logic        o_resend_dropped;
    logic [3:0]  o_acked_node;

    tdma_slot_ack_retransmit_controller i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_opcode            (i_opcode),
        .i_rx_type           (i_rx_type),
        .i_rx_sender         (i_rx_sender),
        .i_rx_sequence       (i_rx_sequence),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_result_kind       (o_result_kind),
        .o_frame_sequence    (o_frame_sequence),
        .o_frame_type        (o_frame_type),
        .o_frame_priority    (o_frame_priority),
        .o_response_expected (o_response_expected),
        .o_cycle_position    (o_cycle_position),
        .o_cycle_number      (o_cycle_number),
        .o_retry_number      (o_retry_number),
        .o_acks_seen         (o_acks_seen),
        .o_queued_for_resend (o_queued_for_resend),
        .o_resend_dropped    (o_resend_dropped),
        .o_acked_node        (o_acked_node)
    );

    // model state of the initiator
    logic [31:0] period_cnt = '0;
    logic [2:0]  cur_pos    = POS_FIRST;
    logic [29:0] cur_cycle  = '0;
    logic [7:0]  data_seq   = '0;
    logic [7:0]  sent_seq   = '0;
    logic        xfer_on    = 1'b0;
    logic [8:0]  ack_map    = '0;
    logic [7:0]  resend_fifo[$];

    t_slot_item  slot_items[$];
    t_frame_cmd  frames_due[$];

    // stimulus side view: ticks issued, transfer state (2 unknown), data sequence
    int          sched_periods = 0;
    int          sched_busy    = 0;
    logic [7:0]  sched_seq     = '0;
    int          items_made    = 0;

    bit          idle_on = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          mismatches = 0;
    int          items_taken = 0;
    int          kinds_seen[6];
    int          drops_seen = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_frame_cmd initiator_next(t_opcode op, logic [7:0] rtype,
                                                  logic [7:0] sender, logic [7:0] rseq);
        t_frame_cmd  r;
        logic [31:0] prev;
        logic [3:0]  node;
        r = '0;
        case (op)
            OP_TICK: begin
                period_cnt = period_cnt + 32'd1;
                prev = period_cnt - 32'd1;
                cur_pos = 3'(prev % PERIODS_PER_CYCLE + 1);
                if (cur_pos == POS_FIRST && period_cnt > 32'd1)
                    cur_cycle = 30'(prev / PERIODS_PER_CYCLE);
                sent_seq = period_cnt[7:0];
                r.kind = KIND_SYNC;
                r.seq = sent_seq;
                r.ftype = MSG_SYNC;
            end
            OP_SLOT_START: begin
                if (!xfer_on && cur_pos == POS_FIRST) begin
                    ack_map = '0;
                    data_seq = data_seq + 8'd1;
                    sent_seq = data_seq;
                    xfer_on = 1'b1;
                    r.kind = KIND_DATA;
                    r.seq = data_seq;
                    r.ftype = MSG_DATA;
                    r.prio = 1'b1;
                    r.resp = 1'b1;
                end else if (!xfer_on && (cur_pos == POS_RESEND || cur_pos == POS_LAST)
                             && resend_fifo.size() > 0) begin
                    sent_seq = resend_fifo.pop_front();
                    ack_map = '0;
                    xfer_on = 1'b1;
                    r.kind = KIND_RESEND;
                    r.seq = sent_seq;
                    r.ftype = MSG_DATA;
                    r.prio = 1'b1;
                    r.resp = 1'b1;
                    r.retry = 1'b1;
                end
            end
            OP_SLOT_END: begin
                if (xfer_on) begin
                    r.acks = 4'($countones(ack_map));
                    if (ack_map != ALL_PEERS) begin
                        if (resend_fifo.size() < RESEND_DEPTH) begin
                            resend_fifo.push_back(sent_seq);
                            r.queued = 1'b1;
                        end else begin
                            r.dropped = 1'b1;
                        end
                    end
                    xfer_on = 1'b0;
                    r.kind = KIND_SUMMARY;
                end
            end
            default: begin
                if (sender >= NODE_FIRST && sender <= NODE_LAST)
                    node = 4'(sender - NODE_BASE);
                else if (sender == NODE_ZERO)
                    node = NODE_ZERO_IDX;
                else
                    node = 4'd0;
                if (xfer_on && rtype == MSG_ACK && rseq == data_seq && node != 4'd0) begin
                    ack_map[node - 4'd1] = 1'b1;
                    r.kind = KIND_ACK;
                    r.node = node;
                end
            end
        endcase
        r.pos = cur_pos;
        r.cyc = cur_cycle;
        return r;
    endfunction

    function automatic logic [2:0] sched_pos();
        if (sched_periods == 0) return POS_FIRST;
        return 3'((sched_periods - 1) % PERIODS_PER_CYCLE + 1);
    endfunction

    function automatic void push_item(t_opcode op, logic [7:0] rtype,
                                      logic [7:0] sender, logic [7:0] rseq);
        t_slot_item it;
        logic [2:0] pos;
        pos = sched_pos();
        // keep the sequence tracking exact: no period one start while unsure
        if (op == OP_SLOT_START && pos == POS_FIRST && sched_busy == 2)
            op = OP_SLOT_END;
        case (op)
            OP_TICK: sched_periods++;
            OP_SLOT_START: begin
                if (sched_busy == 0 && pos == POS_FIRST) begin
                    sched_seq = sched_seq + 8'd1;
                    sched_busy = 1;
                end else if (sched_busy == 0 && (pos == POS_RESEND || pos == POS_LAST)) begin
                    sched_busy = 2;
                end
            end
            OP_SLOT_END: sched_busy = 0;
            default: ;
        endcase
        it.op = op;
        it.rtype = rtype;
        it.sender = sender;
        it.rseq = rseq;
        slot_items.push_back(it);
        items_made++;
    endfunction

    function automatic void push_ctrl(t_opcode op);
        push_item(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endfunction

    function automatic void advance_to(logic [2:0] pos);
        while (sched_pos() != pos)
            push_ctrl(OP_TICK);
    endfunction

    function automatic logic [7:0] node_char(int idx);
        return (idx == NUM_PEERS) ? NODE_ZERO : NODE_BASE + 8'(idx);
    endfunction

    function automatic void send_acks(bit all_peers);
        int nodes[$];
        int j;
        int tmp;
        for (int i = 1; i <= NUM_PEERS; i++)
            if (all_peers || $urandom_range(0, 1) == 1) nodes.push_back(i);
        if (!all_peers && nodes.size() == NUM_PEERS)
            nodes.delete($urandom_range(0, NUM_PEERS - 1));
        for (int i = nodes.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = nodes[i];
            nodes[i] = nodes[j];
            nodes[j] = tmp;
        end
        foreach (nodes[i]) begin
            if ($urandom_range(0, 9) == 0)
                push_item(OP_RX, MSG_ACK, node_char(nodes[i]),
                          sched_seq ^ 8'($urandom_range(1, 255)));
            if ($urandom_range(0, 9) == 0)
                push_item(OP_RX, 8'($urandom_range(0, 255)), node_char(nodes[i]), sched_seq);
            push_item(OP_RX, MSG_ACK, node_char(nodes[i]), sched_seq);
            if ($urandom_range(0, 9) == 0)
                push_item(OP_RX, MSG_ACK, node_char(nodes[i]), sched_seq);
        end
    endfunction

    function automatic void run_cycle(bit with_resend, bit may_complete);
        advance_to(POS_FIRST);
        push_ctrl(OP_SLOT_START);
        if ($urandom_range(0, 9) == 0) push_ctrl(OP_TICK);
        send_acks(may_complete && $urandom_range(0, 3) == 0);
        push_ctrl(OP_SLOT_END);
        if (with_resend) begin
            advance_to(POS_RESEND);
            push_ctrl(OP_SLOT_START);
            send_acks(may_complete && $urandom_range(0, 2) == 0);
            push_ctrl(OP_SLOT_END);
            advance_to(POS_LAST);
            push_ctrl(OP_SLOT_START);
            send_acks(may_complete && $urandom_range(0, 2) == 0);
            push_ctrl(OP_SLOT_END);
        end
    endfunction

    function automatic void noise_burst(int n);
        logic [7:0] rtype;
        logic [7:0] sender;
        logic [7:0] rseq;
        for (int i = 0; i < n; i++) begin
            rtype = 8'($urandom_range(0, 255));
            sender = 8'($urandom_range(0, 255));
            rseq = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 2) == 0) begin
                rtype = MSG_ACK;
                rseq = sched_seq;
                sender = node_char($urandom_range(1, NUM_PEERS));
            end
            push_item(t_opcode'($urandom_range(0, 3)), rtype, sender, rseq);
        end
        push_ctrl(OP_SLOT_END);
    endfunction

    task automatic wait_drained();
        while (slot_items.size() != 0 || i_valid || frames_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t ns", what, got, want, $time);
        mismatches++;
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                frames_due.push_back(initiator_next(t_opcode'(i_opcode), i_rx_type,
                                                    i_rx_sender, i_rx_sequence));
                items_taken++;
            end
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    i_valid <= 1'b0;
                    gap_left--;
                end else if (slot_items.size() > 0) begin
                    i_opcode <= slot_items[0].op;
                    i_rx_type <= slot_items[0].rtype;
                    i_rx_sender <= slot_items[0].sender;
                    i_rx_sequence <= slot_items[0].rseq;
                    void'(slot_items.pop_front());
                    i_valid <= 1'b1;
                    gap_left = idle_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // output stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            stall_left = idle_gap();
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_frame_cmd want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (frames_due.size() == 0) begin
                report_mismatch("unexpected item kind", 32'(o_result_kind), 32'd0);
            end else begin
                want = frames_due.pop_front();
                if (o_result_kind !== want.kind)
                    report_mismatch("result_kind", 32'(o_result_kind), 32'(want.kind));
                if (o_frame_sequence !== want.seq)
                    report_mismatch("frame_sequence", 32'(o_frame_sequence), 32'(want.seq));
                if (o_frame_type !== want.ftype)
                    report_mismatch("frame_type", 32'(o_frame_type), 32'(want.ftype));
                if (o_frame_priority !== want.prio)
                    report_mismatch("frame_priority", 32'(o_frame_priority), 32'(want.prio));
                if (o_response_expected !== want.resp)
                    report_mismatch("response_expected", 32'(o_response_expected),
                                    32'(want.resp));
                if (o_cycle_position !== want.pos)
                    report_mismatch("cycle_position", 32'(o_cycle_position), 32'(want.pos));
                if (o_cycle_number !== want.cyc)
                    report_mismatch("cycle_number", 32'(o_cycle_number), 32'(want.cyc));
                if (o_retry_number !== want.retry)
                    report_mismatch("retry_number", 32'(o_retry_number), 32'(want.retry));
                if (o_acks_seen !== want.acks)
                    report_mismatch("acks_seen", 32'(o_acks_seen), 32'(want.acks));
                if (o_queued_for_resend !== want.queued)
                    report_mismatch("queued_for_resend", 32'(o_queued_for_resend),
                                    32'(want.queued));
                if (o_resend_dropped !== want.dropped)
                    report_mismatch("resend_dropped", 32'(o_resend_dropped),
                                    32'(want.dropped));
                if (o_acked_node !== want.node)
                    report_mismatch("acked_node", 32'(o_acked_node), 32'(want.node));
                kinds_seen[want.kind]++;
                if (want.dropped) drops_seen++;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [7:0] s;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: data right after reset, ack filtering, idle slots, resend
        push_ctrl(OP_SLOT_START);
        s = sched_seq;
        push_ctrl(OP_SLOT_START);
        push_item(OP_RX, MSG_ACK, NODE_FIRST, s);
        push_item(OP_RX, MSG_ACK, NODE_ZERO, s);
        push_item(OP_RX, MSG_ACK, NODE_LAST, s);
        push_item(OP_RX, MSG_ACK, NODE_BASE, s);
        push_item(OP_RX, MSG_ACK, NODE_ALPHA, s);
        push_item(OP_RX, MSG_ACK, NODE_NONE, s);
        push_item(OP_RX, 8'hFF, NODE_FIRST + 8'd1, s);
        push_item(OP_RX, MSG_ACK, NODE_FIRST + 8'd1, s - 8'd1);
        push_ctrl(OP_TICK);
        push_ctrl(OP_SLOT_END);
        push_ctrl(OP_SLOT_END);
        push_item(OP_RX, MSG_ACK, NODE_FIRST, s);
        push_ctrl(OP_TICK);
        push_ctrl(OP_SLOT_START);
        push_ctrl(OP_TICK);
        push_ctrl(OP_SLOT_START);
        push_ctrl(OP_TICK);
        push_ctrl(OP_SLOT_START);
        push_item(OP_RX, MSG_ACK, NODE_FIRST + 8'd2, s);
        push_ctrl(OP_SLOT_END);
        push_ctrl(OP_TICK);
        push_ctrl(OP_SLOT_START);
        push_ctrl(OP_SLOT_END);
        push_ctrl(OP_TICK);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            idle_on = (ph % 3 != 0);
            if (ph == 3) begin
                // fill the resend queue past full, then run cycles with resend slots
                for (int c = 0; c < RESEND_DEPTH + 4; c++) run_cycle(1'b0, 1'b0);
                for (int c = 0; c < 3; c++) run_cycle(1'b1, 1'b0);
            end else begin
                items_made = 0;
                while (items_made < PHASE_ITEMS) begin
                    if ($urandom_range(0, 9) < 7)
                        run_cycle($urandom_range(0, 3) != 0, 1'b1);
                    else
                        noise_burst($urandom_range(3, 15));
                end
            end
            wait_drained();
        end

        repeat (5) @(posedge i_clk);
        $display("checked %0d items: %0d sync, %0d data, %0d resend, %0d ignored",
                 items_taken, kinds_seen[KIND_SYNC], kinds_seen[KIND_DATA],
                 kinds_seen[KIND_RESEND], kinds_seen[KIND_NONE]);
        $display("slot summaries %0d (%0d dropped on full queue), acks recorded %0d",
                 kinds_seen[KIND_SUMMARY], drops_seen, kinds_seen[KIND_ACK]);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
